// ===== design/tclw_pkg.sv =====
// Package for the text console line writer: constants, codes, state
// encoding and the request bundle of the shared modulo unit.
// No dependencies.
package tclw_pkg;

   localparam int unsigned STORE_CHARS = 16384;
   localparam int unsigned ADDR_W      = 14;
   localparam int unsigned MAX_WIDTH   = 128;
   localparam int unsigned WIN_AW      = 7;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COL1  = 8'h01;
   localparam logic [7:0] CH_COL2  = 8'h02;

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   localparam logic       REG_WIDTH = 1'b0;
   localparam logic       REG_COUNT = 1'b1;

   localparam logic [6:0]  WIDTH_RST = 7'd38;
   localparam logic [14:0] COUNT_RST = 15'd431;
   localparam logic [13:0] ROW_RST   = 14'd430;
   localparam logic [14:0] COUNT_MAX = 15'd16384;

   typedef enum logic [18:0] {
      S_CLR    = 19'h00001,
      S_IDLE   = 19'h00002,
      S_DTOP   = 19'h00004,
      S_SCAN_A = 19'h00008,
      S_SCAN_D = 19'h00010,
      S_P1     = 19'h00020,
      S_P2     = 19'h00040,
      S_NL_MUL = 19'h00080,
      S_NL_CLR = 19'h00100,
      S_CH     = 19'h00200,
      S_ST_MUL = 19'h00400,
      S_ST_WR  = 19'h00800,
      S_POP    = 19'h01000,
      S_MODW   = 19'h02000,
      S_RD_MUL = 19'h04000,
      S_RD_A   = 19'h08000,
      S_RD_D   = 19'h10000,
      S_FIN    = 19'h20000,
      S_OUT    = 19'h40000
   } state_type;

   typedef struct packed {
      logic        start;
      logic [13:0] x;
      logic [14:0] d;
   } mod_req_type;

endpackage

// ===== design/tclw_if.sv =====
// Request and response channel interfaces of the text console line writer.
// Depends on nothing but the field widths fixed here.
interface tclw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  char_code;
   logic        last_in_message;
   logic [13:0] read_row;
   logic [6:0]  read_column;

   modport source (output valid, action, char_code, last_in_message, read_row,
                   read_column, input ready);
   modport sink (input valid, action, char_code, last_in_message, read_row,
                 read_column, output ready);
endinterface

interface tclw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  cell_value;
   logic [13:0] newest_row;
   logic [6:0]  cursor_column;

   modport source (output valid, cell_value, newest_row, cursor_column, input ready);
   modport sink (input valid, cell_value, newest_row, cursor_column, output ready);
endinterface

// ===== design/text_console_line_writer_core.sv =====
// Top level of the text console line writer: sequencer, line store,
// lookahead window and configuration registers. Uses tclw_pkg, tclw_if, tclw_modu.
//
//   channel  | direction | handshake          | contents
//   req_ch   | in        | valid/ready        | action, char, last flag, read cell
//   rsp_ch   | out       | valid/ready        | cell value, newest row, cursor column
//   apb      | in        | psel/penable/pready| line_width at 0x0, line_count at 0x4
//
// One transaction at a time. A read goes through the modulo unit, a multiply and a
// store read; each printed byte scans the window entries, then goes through the
// modulo unit for the store write, and a new line first clears the w cells of its row.
// After reset and on a clear the store is swept with req_ch.ready low. A waiting
// response does not block the next request.
module text_console_line_writer_core (
   input  logic         clock,
   input  logic         reset,
   tclw_req_if.sink     req_ch,
   tclw_rsp_if.source   rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   tclw_pkg::state_type st_ff, st_in, mret_ff, mret_in;
   logic [6:0]  lw_ff, lw_in;
   logic [14:0] lc_ff, lc_in;
   logic [6:0]  col_ff, col_in;
   logic [13:0] row_ff, row_in;
   logic        ret_ff, ret_in, colour_ff, colour_in, mstart_ff, mstart_in;
   logic [7:0]  wfill_ff, wfill_in;
   logic [6:0]  whead_ff, whead_in;
   logic        atend_ff, atend_in;
   logic [6:0]  rcol_ff, rcol_in;
   logic [7:0]  l_ff, l_in, lim_ff, lim_in, wlen_ff, wlen_in, byte_ff, byte_in;
   logic [13:0] base_ff, base_in;
   logic [7:0]  idx_ff, idx_in;
   logic [13:0] clr_ff, clr_in;
   logic        clr_reply_ff, clr_reply_in;
   logic [7:0]  cell_ff, cell_in;
   logic        rv_ff, rv_in;
   logic [7:0]  rcell_ff, rcell_in;
   logic [13:0] rrow_ff, rrow_in;
   logic [6:0]  rcolo_ff, rcolo_in;

   logic [7:0]  win_mem [tclw_pkg::MAX_WIDTH];
   logic        win_we;
   logic [6:0]  win_wa, win_ra;
   logic [7:0]  win_wd, win_q_ff;

   logic [7:0]  st_mem [tclw_pkg::STORE_CHARS];
   logic        st_we;
   logic [13:0] st_wa, st_ra;
   logic [7:0]  st_wd, st_q_ff;

   tclw_pkg::mod_req_type mreq;
   logic        mdone;
   logic [13:0] mrem;

   logic [7:0]  ew;
   logic [14:0] ec, ec_m1;
   logic [13:0] mul_a;
   logic [21:0] prod;
   logic        acc, wr_cfg;

   assign ew    = (lw_ff == 7'd0) ? 8'd1 : {1'b0, lw_ff};
   assign ec    = (lc_ff == 15'd0) ? 15'd1 :
                  ((lc_ff > tclw_pkg::COUNT_MAX) ? tclw_pkg::COUNT_MAX : lc_ff);
   assign ec_m1 = ec - 15'd1;
   assign mul_a = (st_ff == tclw_pkg::S_NL_MUL) ? row_ff : mrem;
   assign prod  = mul_a * ew;

   assign req_ch.ready = (st_ff == tclw_pkg::S_IDLE);
   assign acc          = req_ch.valid && req_ch.ready;
   assign wr_cfg       = psel && penable && pwrite;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == tclw_pkg::REG_COUNT) ? {17'd0, lc_ff} : {25'd0, lw_ff};

   assign rsp_ch.valid         = rv_ff;
   assign rsp_ch.cell_value    = rcell_ff;
   assign rsp_ch.newest_row    = rrow_ff;
   assign rsp_ch.cursor_column = rcolo_ff;

   tclw_modu u_modu (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .done  (mdone),
      .rem   (mrem)
   );

   always_comb begin
      logic       take, ends;
      logic [6:0] colt;
      logic [8:0] reach;
      logic [14:0] nxt;
      logic [7:0] cnext;
      take  = 1'b0;
      ends  = 1'b0;
      colt  = 7'd0;
      reach = 9'd0;
      nxt   = 15'd0;
      cnext = 8'd0;

      st_in = st_ff;  mret_in = mret_ff;
      lw_in = lw_ff;  lc_in = lc_ff;
      col_in = col_ff; row_in = row_ff;
      ret_in = ret_ff; colour_in = colour_ff; mstart_in = mstart_ff;
      wfill_in = wfill_ff; whead_in = whead_ff; atend_in = atend_ff;
      rcol_in = rcol_ff;
      l_in = l_ff; lim_in = lim_ff; wlen_in = wlen_ff; byte_in = byte_ff;
      base_in = base_ff; idx_in = idx_ff;
      clr_in = clr_ff; clr_reply_in = clr_reply_ff;
      cell_in = cell_ff;
      rv_in = rv_ff; rcell_in = rcell_ff; rrow_in = rrow_ff; rcolo_in = rcolo_ff;

      win_we = 1'b0; win_wa = whead_ff + wfill_ff[6:0]; win_wd = req_ch.char_code;
      win_ra = whead_ff + l_ff[6:0];
      st_we = 1'b0; st_wa = clr_ff; st_wd = tclw_pkg::CH_SPACE;
      st_ra = base_ff + {7'd0, rcol_ff};
      mreq.start = 1'b0; mreq.x = row_ff; mreq.d = ec;

      if (wr_cfg) begin
         if (paddr[2] == tclw_pkg::REG_COUNT) lc_in = pwdata[14:0];
         else lw_in = pwdata[6:0];
      end
      if (rv_ff && rsp_ch.ready) rv_in = 1'b0;

      unique case (st_ff)
         tclw_pkg::S_CLR: begin
            st_we = 1'b1;
            if (clr_ff == '1) st_in = clr_reply_ff ? tclw_pkg::S_FIN : tclw_pkg::S_IDLE;
            else clr_in = clr_ff + 14'd1;
         end
         tclw_pkg::S_IDLE: begin
            if (acc) begin
               cell_in = 8'd0;
               rcol_in = req_ch.read_column;
               unique case (req_ch.action)
                  tclw_pkg::ACT_PUT: begin
                     take = (req_ch.char_code != 8'd0);
                     ends = req_ch.last_in_message || !take;
                     if (mstart_ff && take) begin
                        if (req_ch.char_code == tclw_pkg::CH_COL1 ||
                            req_ch.char_code == tclw_pkg::CH_COL2) begin
                           colour_in = 1'b1;
                           take = 1'b0;
                        end else begin
                           colour_in = 1'b0;
                        end
                     end
                     mstart_in = ends;
                     atend_in  = ends;
                     if (take && wfill_ff < 8'(tclw_pkg::MAX_WIDTH)) begin
                        win_we   = 1'b1;
                        wfill_in = wfill_ff + 8'd1;
                     end
                     st_in = (take || ends) ? tclw_pkg::S_DTOP : tclw_pkg::S_FIN;
                  end
                  tclw_pkg::ACT_READ: begin
                     mreq.start = 1'b1;
                     mreq.x     = req_ch.read_row;
                     mret_in    = tclw_pkg::S_RD_MUL;
                     st_in      = tclw_pkg::S_MODW;
                  end
                  tclw_pkg::ACT_CLEAR: begin
                     clr_in       = 14'd0;
                     clr_reply_in = 1'b1;
                     st_in        = tclw_pkg::S_CLR;
                  end
                  tclw_pkg::ACT_NOP: st_in = tclw_pkg::S_FIN;
               endcase
            end
         end
         tclw_pkg::S_DTOP: begin
            if (wfill_ff == 8'd0) begin
               st_in = tclw_pkg::S_FIN;
            end else begin
               lim_in = (wfill_ff < ew) ? wfill_ff : ew;
               l_in   = 8'd0;
               st_in  = tclw_pkg::S_SCAN_A;
            end
         end
         tclw_pkg::S_SCAN_A: st_in = tclw_pkg::S_SCAN_D;
         tclw_pkg::S_SCAN_D: begin
            if (l_ff == 8'd0) byte_in = win_q_ff;
            if (win_q_ff <= tclw_pkg::CH_SPACE) begin
               wlen_in = l_ff;
               st_in   = tclw_pkg::S_P1;
            end else if (l_ff + 8'd1 == lim_ff) begin
               if (wfill_ff >= ew) begin
                  wlen_in = ew;
                  st_in   = tclw_pkg::S_P1;
               end else if (atend_ff) begin
                  wlen_in = wfill_ff;
                  st_in   = tclw_pkg::S_P1;
               end else begin
                  st_in = tclw_pkg::S_FIN;
               end
            end else begin
               l_in  = l_ff + 8'd1;
               st_in = tclw_pkg::S_SCAN_A;
            end
         end
         tclw_pkg::S_P1: begin
            colt  = ({1'b0, col_ff} >= ew) ? 7'd0 : col_ff;
            reach = {2'd0, colt} + {1'b0, wlen_ff};
            if (wlen_ff != ew && reach > {1'b0, ew}) colt = 7'd0;
            col_in = colt;
            if (ret_ff) begin
               // return: step back one line, wrapping to the last line
               if (row_ff == 14'd0 || {1'b0, row_ff} >= ec) row_in = ec_m1[13:0];
               else row_in = row_ff - 14'd1;
               ret_in = 1'b0;
            end
            st_in = tclw_pkg::S_P2;
         end
         tclw_pkg::S_P2: begin
            if (col_ff == 7'd0) begin
               nxt    = {1'b0, row_ff} + 15'd1;
               row_in = (nxt >= ec) ? 14'd0 : nxt[13:0];
               st_in  = tclw_pkg::S_NL_MUL;
            end else begin
               st_in = tclw_pkg::S_CH;
            end
         end
         tclw_pkg::S_NL_MUL: begin
            base_in = prod[13:0];
            idx_in  = 8'd0;
            st_in   = tclw_pkg::S_NL_CLR;
         end
         tclw_pkg::S_NL_CLR: begin
            st_we = 1'b1;
            st_wa = base_ff + {6'd0, idx_ff};
            if (idx_ff + 8'd1 == ew) st_in = tclw_pkg::S_CH;
            else idx_in = idx_ff + 8'd1;
         end
         tclw_pkg::S_CH: begin
            if (byte_ff == tclw_pkg::CH_NL) begin
               col_in = 7'd0;
               st_in  = tclw_pkg::S_POP;
            end else if (byte_ff == tclw_pkg::CH_CR) begin
               col_in = 7'd0;
               ret_in = 1'b1;
               st_in  = tclw_pkg::S_POP;
            end else begin
               mreq.start = 1'b1;
               mret_in    = tclw_pkg::S_ST_MUL;
               st_in      = tclw_pkg::S_MODW;
            end
         end
         tclw_pkg::S_ST_MUL: begin
            base_in = prod[13:0];
            st_in   = tclw_pkg::S_ST_WR;
         end
         tclw_pkg::S_ST_WR: begin
            st_we  = 1'b1;
            st_wa  = base_ff + {7'd0, col_ff};
            st_wd  = {colour_ff | byte_ff[7], byte_ff[6:0]};
            cnext  = {1'b0, col_ff} + 8'd1;
            col_in = (cnext >= ew) ? 7'd0 : cnext[6:0];
            st_in  = tclw_pkg::S_POP;
         end
         tclw_pkg::S_POP: begin
            wfill_in = wfill_ff - 8'd1;
            whead_in = whead_ff + 7'd1;
            st_in    = tclw_pkg::S_DTOP;
         end
         tclw_pkg::S_MODW: if (mdone) st_in = mret_ff;
         tclw_pkg::S_RD_MUL: begin
            base_in = prod[13:0];
            st_in   = tclw_pkg::S_RD_A;
         end
         tclw_pkg::S_RD_A: st_in = tclw_pkg::S_RD_D;
         tclw_pkg::S_RD_D: begin
            cell_in = st_q_ff;
            st_in   = tclw_pkg::S_FIN;
         end
         tclw_pkg::S_FIN: begin
            mreq.start = 1'b1;
            mret_in    = tclw_pkg::S_OUT;
            st_in      = tclw_pkg::S_MODW;
         end
         tclw_pkg::S_OUT: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               rcell_in = cell_ff;
               rrow_in  = mrem;
               rcolo_in = col_ff;
               st_in    = tclw_pkg::S_IDLE;
            end
         end
         default: st_in = tclw_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_wa] <= win_wd;
      win_q_ff <= win_mem[win_ra];
      if (st_we) st_mem[st_wa] <= st_wd;
      st_q_ff <= st_mem[st_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= tclw_pkg::S_CLR;
         mret_ff      <= tclw_pkg::S_IDLE;
         clr_ff       <= 14'd0;
         clr_reply_ff <= 1'b0;
         lw_ff        <= tclw_pkg::WIDTH_RST;
         lc_ff        <= tclw_pkg::COUNT_RST;
         col_ff       <= 7'd0;
         row_ff       <= tclw_pkg::ROW_RST;
         ret_ff       <= 1'b0;
         colour_ff    <= 1'b0;
         mstart_ff    <= 1'b1;
         wfill_ff     <= 8'd0;
         whead_ff     <= 7'd0;
         rv_ff        <= 1'b0;
      end else begin
         st_ff        <= st_in;
         mret_ff      <= mret_in;
         clr_ff       <= clr_in;
         clr_reply_ff <= clr_reply_in;
         lw_ff        <= lw_in;
         lc_ff        <= lc_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ret_ff       <= ret_in;
         colour_ff    <= colour_in;
         mstart_ff    <= mstart_in;
         wfill_ff     <= wfill_in;
         whead_ff     <= whead_in;
         rv_ff        <= rv_in;
      end
      atend_ff <= atend_in;
      rcol_ff  <= rcol_in;
      l_ff     <= l_in;
      lim_ff   <= lim_in;
      wlen_ff  <= wlen_in;
      byte_ff  <= byte_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      cell_ff  <= cell_in;
      rcell_ff <= rcell_in;
      rrow_ff  <= rrow_in;
      rcolo_ff <= rcolo_in;
   end
endmodule

// ===== design/tclw_modu.sv =====
// Shared restoring modulo unit: remainder of a 14-bit value by a 15-bit
// divisor, one bit per cycle. Depends on tclw_pkg.
module tclw_modu (
   input  logic                 clock,
   input  logic                 reset,
   input  tclw_pkg::mod_req_type req,
   output logic                 done,
   output logic [13:0]          rem
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [13:0] xs_ff, xs_in;
   logic [14:0] d_ff, d_in;
   logic [14:0] rem_ff, rem_in;
   logic [14:0] trial;

   assign trial = {rem_ff[13:0], xs_ff[13]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      xs_in   = xs_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         xs_in   = req.x;
         d_in    = req.d;
         rem_in  = 15'd0;
      end else if (busy_ff) begin
         rem_in = (trial >= d_ff) ? trial - d_ff : trial;
         xs_in  = {xs_ff[12:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd13) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      xs_ff  <= xs_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[13:0];
endmodule

// ===== design/tclw_checker.sv =====
// Port-level checker for the text console line writer, bound to the top.
// Depends only on the top level's ports.
module tclw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_cell,
   input logic [6:0]  rsp_col
);
   // the store sweep after reset keeps requests out
   a_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during store sweep");

   // column always lands below the widest line
   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_col != 7'h7f)
      else $error("cursor column out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell))
      else $error("response dropped or changed while stalled");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("response withdrawn without a transaction");
endmodule

bind text_console_line_writer_core tclw_checker u_tclw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_cell  (rsp_ch.cell_value),
   .rsp_col   (rsp_ch.cursor_column)
);

// ===== test/tb_text_console_line_writer_core.sv =====
// Testbench for text_console_line_writer_core: directed table, then random
// messages, reads and clears under several line geometries, checked against
// a local line-writer predictor. Uses tclw_pkg and tclw_if.
`timescale 1ns / 1ps

module tb_text_console_line_writer_core;

   localparam int unsigned IDLE_LIMIT = 250000;
   localparam int unsigned PHASE_ITEMS = 70;

   typedef struct {
      logic [1:0]  action;
      logic [7:0]  ch;
      logic        last;
      logic [13:0] row;
      logic [6:0]  col;
   } txn_type;

   typedef struct {
      logic [7:0]  cval;
      logic [13:0] row;
      logic [6:0]  col;
   } line_rsp_type;

   typedef struct {
      txn_type      t;
      bit           typed;
      line_rsp_type r;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   tclw_req_if req_if ();
   tclw_rsp_if rsp_if ();

   text_console_line_writer_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_if.sink), .rsp_ch(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // console predictor state
   logic [7:0]  con_store [tclw_pkg::STORE_CHARS];
   logic [7:0]  con_win [tclw_pkg::MAX_WIDTH];
   int unsigned con_width, con_count, con_col, con_row, con_fill;
   bit          con_ret, con_colour, con_msg_start;

   line_rsp_type pending_rsp[$];
   line_rsp_type typed_rsp[$];
   bit           typed_flag[$];
   txn_type      stim_q[$];
   int unsigned mismatches, n_sent, n_rsp, n_clears, n_cfg;
   int unsigned stall_pct;
   bit          hold_req, no_gaps;

   function automatic int unsigned eff_w();
      int unsigned w;
      w = con_width;
      if (w < 1) w = 1;
      if (w > tclw_pkg::MAX_WIDTH) w = tclw_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned eff_c();
      int unsigned c;
      c = con_count;
      if (c < 1) c = 1;
      if (c > tclw_pkg::STORE_CHARS) c = tclw_pkg::STORE_CHARS;
      return c;
   endfunction

   function automatic int unsigned cell_at(int unsigned r, int unsigned c);
      return ((r % eff_c()) * eff_w() + c) % tclw_pkg::STORE_CHARS;
   endfunction

   function automatic void wipe_store();
      for (int i = 0; i < tclw_pkg::STORE_CHARS; i++) con_store[i] = tclw_pkg::CH_SPACE;
   endfunction

   function automatic void start_line();
      con_col = 0;
      con_row = con_row + 1;
      if (con_row >= eff_c()) con_row = 0;
      for (int unsigned i = 0; i < eff_w(); i++)
         con_store[cell_at(con_row, i)] = tclw_pkg::CH_SPACE;
   endfunction

   function automatic void emit_byte(logic [7:0] c, int unsigned wlen);
      int unsigned w;
      w = eff_w();
      if (con_col >= w) con_col = 0;
      if (wlen != w && con_col + wlen > w) con_col = 0;
      if (con_ret) begin
         if (con_row == 0 || con_row >= eff_c()) con_row = eff_c() - 1;
         else con_row = con_row - 1;
         con_ret = 0;
      end
      if (con_col == 0) start_line();
      if (c == tclw_pkg::CH_NL) begin
         con_col = 0;
      end else if (c == tclw_pkg::CH_CR) begin
         con_col = 0;
         con_ret = 1;
      end else begin
         con_store[cell_at(con_row, con_col)] = c | (con_colour ? 8'h80 : 8'h00);
         con_col++;
         if (con_col >= w) con_col = 0;
      end
   endfunction

   function automatic void flush_window(bit at_end);
      int unsigned w, lim, l;
      while (con_fill > 0) begin
         w = eff_w();
         lim = con_fill < w ? con_fill : w;
         for (l = 0; l < lim; l++)
            if (con_win[l] <= tclw_pkg::CH_SPACE) break;
         if (l == lim) begin
            if (con_fill >= w) l = w;
            else if (at_end) l = con_fill;
            else break;
         end
         emit_byte(con_win[0], l);
         con_fill--;
         for (int unsigned i = 0; i < con_fill; i++) con_win[i] = con_win[i+1];
      end
   endfunction

   function automatic line_rsp_type console_step(txn_type t);
      line_rsp_type r;
      bit ends, take;
      r.cval = 8'h00;
      if (t.action == tclw_pkg::ACT_PUT) begin
         ends = t.last || t.ch == 8'h00;
         take = t.ch != 8'h00;
         if (con_msg_start && take) begin
            if (t.ch == tclw_pkg::CH_COL1 || t.ch == tclw_pkg::CH_COL2) begin
               con_colour = 1;
               take = 0;
            end else begin
               con_colour = 0;
            end
         end
         con_msg_start = 0;
         if (take) begin
            if (con_fill < tclw_pkg::MAX_WIDTH) con_win[con_fill++] = t.ch;
            flush_window(0);
         end
         if (ends) begin
            flush_window(1);
            con_msg_start = 1;
         end
      end else if (t.action == tclw_pkg::ACT_READ) begin
         r.cval = con_store[cell_at(t.row, t.col)];
      end else if (t.action == tclw_pkg::ACT_CLEAR) begin
         wipe_store();
      end
      r.row = 14'((con_row % eff_c()) & 16'h3FFF);
      r.col = 7'(con_col);
      return r;
   endfunction

   // acceptance monitor and scoreboard
   always @(posedge clock) begin
      line_rsp_type got, want;
      txn_type t;
      if (!reset && req_if.valid && req_if.ready) begin
         t.action = req_if.action;
         t.ch = req_if.char_code;
         t.last = req_if.last_in_message;
         t.row = req_if.read_row;
         t.col = req_if.read_column;
         want = console_step(t);
         if (typed_flag.size() > 0 && typed_flag.pop_front()) want = typed_rsp.pop_front();
         pending_rsp.push_back(want);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_rsp++;
         got.cval = rsp_if.cell_value;
         got.row = rsp_if.newest_row;
         got.col = rsp_if.cursor_column;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: cell %h row %0d col %0d",
                                           got.cval, got.row, got.col);
         end else begin
            want = pending_rsp.pop_front();
            if (got.cval !== want.cval || got.row !== want.row || got.col !== want.col) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: exp cell %h row %0d col %0d, got cell %h row %0d col %0d",
                           n_rsp, want.cval, want.row, want.col, got.cval, got.row, got.col);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   int unsigned quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tb_text_console_line_writer_core: FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // response side back-pressure
   initial begin
      int unsigned tick;
      tick = 0;
      stall_pct = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 400 == 0) stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (1500) @(posedge clock);
            hold_req = 0;
         end else
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic reg_write(logic idx, int unsigned val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == tclw_pkg::REG_WIDTH) con_width = val & 32'h7F;
      else con_count = val & 32'h7FFF;
      n_cfg++;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_all();
      int unsigned burst, gap;
      txn_type t;
      while (stim_q.size() > 0) begin
         burst = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 8);
         while (burst > 0 && stim_q.size() > 0) begin
            t = stim_q.pop_front();
            req_if.action <= t.action;
            req_if.char_code <= t.ch;
            req_if.last_in_message <= t.last;
            req_if.read_row <= t.row;
            req_if.read_column <= t.col;
            req_if.valid <= 1'b1;
            do @(posedge clock); while (!req_if.ready);
            n_sent++;
            burst--;
         end
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic drain_rsp();
      do @(posedge clock); while (pending_rsp.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic txn_type mk(logic [1:0] a, logic [7:0] c, logic l,
                                  logic [13:0] r = 0, logic [6:0] k = 0);
      txn_type t;
      t.action = a; t.ch = c; t.last = l; t.row = r; t.col = k;
      return t;
   endfunction

   function automatic logic [7:0] word_char();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(8'h80, 8'hFF));
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 9))
         0: return tclw_pkg::CH_NL;
         1: return tclw_pkg::CH_CR;
         2: return 8'($urandom_range(8'h03, 8'h1F));
         default: return tclw_pkg::CH_SPACE;
      endcase
   endfunction

   // one message of words with random content; returns item count
   function automatic int unsigned queue_message(int unsigned w);
      logic [7:0] bytes[$];
      int unsigned nwords, wl;
      if ($urandom_range(0, 2) == 0)
         bytes.push_back($urandom_range(0, 1) ? tclw_pkg::CH_COL1 : tclw_pkg::CH_COL2);
      nwords = $urandom_range(1, 5);
      for (int i = 0; i < nwords; i++) begin
         wl = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w + 3) : $urandom_range(1, 9);
         if (wl > 40) wl = 40;
         for (int j = 0; j < wl; j++) bytes.push_back(word_char());
         if (i != nwords - 1 || $urandom_range(0, 3) == 0) bytes.push_back(sep_char());
      end
      if ($urandom_range(0, 9) == 0) begin
         foreach (bytes[i]) stim_q.push_back(mk(tclw_pkg::ACT_PUT, bytes[i], 1'b0));
         stim_q.push_back(mk(tclw_pkg::ACT_PUT, 8'h00, 1'($urandom_range(0, 1))));
         return bytes.size() + 1;
      end
      foreach (bytes[i])
         stim_q.push_back(mk(tclw_pkg::ACT_PUT, bytes[i], i == bytes.size() - 1));
      return bytes.size();
   endfunction

   function automatic void queue_random(int unsigned want, bit with_clear);
      int unsigned made, c;
      made = 0;
      c = eff_c();
      while (made < want) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               stim_q.push_back(mk(tclw_pkg::ACT_READ, 8'($urandom), 1'($urandom),
                  $urandom_range(0, 1) ? 14'($urandom_range(0, c < 20 ? c - 1 : 19)) :
                                         14'($urandom),
                  7'($urandom_range(0, 127))));
               made++;
            end
            2: begin
               if ($urandom_range(0, 1))
                  stim_q.push_back(mk(tclw_pkg::ACT_PUT, 8'($urandom), 1'($urandom),
                                      14'($urandom), 7'($urandom)));
               else
                  stim_q.push_back(mk(tclw_pkg::ACT_NOP, 8'($urandom), 1'($urandom),
                                      14'($urandom), 7'($urandom)));
               made++;
            end
            default: made += queue_message(eff_w());
         endcase
         if (with_clear && made > want / 2) begin
            stim_q.push_back(mk(tclw_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom),
                                14'($urandom), 7'($urandom)));
            n_clears++;
            with_clear = 0;
         end
      end
   endfunction

   int unsigned phase_w[7] = '{1, 127, 0, 127, 20, 80, 38};
   int unsigned phase_c[7] = '{129, 16384, 0, 1, 32767, 200, 431};

   initial begin
      dir_row_type dir_tab[$];
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_if.valid = 1'b0; req_if.action = tclw_pkg::ACT_NOP; req_if.char_code = '0;
      req_if.last_in_message = 1'b0; req_if.read_row = '0; req_if.read_column = '0;
      hold_req = 0; no_gaps = 0;
      mismatches = 0; n_sent = 0; n_rsp = 0; n_clears = 0; n_cfg = 0;
      con_width = tclw_pkg::WIDTH_RST; con_count = tclw_pkg::COUNT_RST; con_col = 0;
      con_row = tclw_pkg::ROW_RST;
      con_fill = 0; con_ret = 0; con_colour = 0; con_msg_start = 1;
      wipe_store();
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, extremes, colour, CR/NL, zero byte, clear
      dir_tab = '{
         '{mk(tclw_pkg::ACT_READ, 8'h00, 1'b0, 14'd0, 7'd0), 1, '{8'h20, 14'd430, 7'd0}},
         '{mk(tclw_pkg::ACT_READ, 8'hFF, 1'b1, 14'h3FFF, 7'h7F), 1, '{8'h20, 14'd430, 7'd0}},
         '{mk(tclw_pkg::ACT_NOP, 8'h41, 1'b1, 14'h3FFF, 7'h7F), 1, '{8'h00, 14'd430, 7'd0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_COL1, 1'b0), 1, '{8'h00, 14'd430, 7'd0}},
         '{mk(tclw_pkg::ACT_PUT, "H", 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, "i", 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_SPACE, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, "x", 1'b1), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_READ, 8'h00, 1'b0, 14'd0, 7'd0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_CR, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, "Z", 1'b1), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_NL, 1'b1), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_COL2, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, 8'h80, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, 8'hFF, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, 8'h00, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_READ, 8'h00, 1'b0, 14'd1, 7'd0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_PUT, tclw_pkg::CH_COL1, 1'b1), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_CLEAR, 8'h00, 1'b0), 0, '{0, 0, 0}},
         '{mk(tclw_pkg::ACT_READ, 8'h00, 1'b0, 14'd0, 7'd0), 0, '{0, 0, 0}}
      };
      foreach (dir_tab[i]) begin
         stim_q.push_back(dir_tab[i].t);
         typed_flag.push_back(dir_tab[i].typed);
         if (dir_tab[i].typed) typed_rsp.push_back(dir_tab[i].r);
      end
      n_clears++;
      send_all();
      queue_random(PHASE_ITEMS, 0);
      send_all();
      drain_rsp();

      foreach (phase_w[p]) begin
         reg_write(tclw_pkg::REG_WIDTH, phase_w[p]);
         reg_write(tclw_pkg::REG_COUNT, phase_c[p]);
         no_gaps = (p % 3 == 1);
         queue_random(PHASE_ITEMS / 2, p == 1 || p == 5);
         send_all();
         if (p == 2) hold_req = 1;
         queue_random(PHASE_ITEMS / 2, 0);
         send_all();
         drain_rsp();
      end

      if (pending_rsp.size() != 0) mismatches++;
      $display("%0d requests, %0d responses, %0d register writes, %0d clears, 8 geometries",
               n_sent, n_rsp, n_cfg, n_clears);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("tb_text_console_line_writer_core: PASS");
      else
         $display("tb_text_console_line_writer_core: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
design/tclw_pkg.sv
design/tclw_if.sv
design/tclw_modu.sv
design/text_console_line_writer_core.sv
design/tclw_checker.sv
test/tb_text_console_line_writer_core.sv
